### rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_TAIL = 3'd0,
    KIND_INS_HEAD = 3'd1,
    KIND_SEARCH   = 3'd2,
    KIND_REM_HEAD = 3'd3,
    KIND_DUMP     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_e                  status;
    logic                     last;
  } res_beat_t;

endpackage

### rtl/cdq_in_if.sv
interface cdq_in_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

### rtl/cdq_out_if.sv
interface cdq_out_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [1:0]               status;
  logic                     last;

  modport source (output valid, output result_value, output status, output last, input ready);
  modport sink   (input valid, input result_value, input status, input last, output ready);
endinterface

### rtl/circular_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit values in a DEPTH-entry ring held in a
// single-port-read, single-port-write RAM. Inserts and head removals take one beat in and
// give one result beat, registered through the response state into the output register;
// a new command is taken once that beat has moved into the output register. Search reads
// one entry per cycle from the head until it finds the value or has inspected every entry,
// at most the fill count (on an empty queue it answers without a read); dump gives
// fill-count beats (one EMPTY beat on an empty queue), one per cycle while the sink keeps
// up, paced by the one RAM read each cycle. Unused kinds are absorbed without a result. RAM
// contents are not cleared at reset and need no clearing pass: only written slots are ever read.
module circular_deque_with_search
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cdq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_no_rw_same_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("RAM read and write in the same cycle");

  a_we_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (in_i.valid && in_i.ready))
    else $error("RAM write outside of an accepted beat");

  a_busy_after_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.kind <= KIND_W'(KIND_DUMP)) |=> !in_i.ready)
    else $error("ready did not drop after a command");

  a_raddr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (int'(mem_raddr) < DEPTH))
    else $error("RAM read address out of range");

endmodule

### rtl/cdq_mem.sv
module cdq_mem
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cdq_ctrl.sv
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  cdq_in_if.sink                   in_i,
  cdq_out_if.source                out_o,
  output logic                     mem_we_o,
  output logic [AW-1:0]            mem_waddr_o,
  output logic signed [DATA_W-1:0] mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AW-1:0]            mem_raddr_o,
  input  logic signed [DATA_W-1:0] mem_rdata_i
);

  state_e                   state_q, state_d;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic                     dump_q, dump_d;
  status_e                  resp_q, resp_d;
  logic signed [DATA_W-1:0] val_q;
  logic                     out_valid_q;
  res_beat_t                out_q;
  res_beat_t                beat;
  logic                     out_load;
  logic                     slot_free;
  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     last_ent;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign last_ent   = ((CW'(idx_q) + CW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    dump_d      = dump_q;
    resp_d      = resp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ring_pos(head_q, count_q[AW-1:0]);
    mem_wdata_o = in_i.value;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    out_load    = 1'b0;
    beat        = '{result_value: '0, status: STAT_OK, last: 1'b1};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          case (kind_e'(in_i.kind))
            KIND_INS_TAIL: begin
              state_d = ST_RESP;
              resp_d  = full ? STAT_FULL : STAT_OK;
              if (!full) begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            KIND_INS_HEAD: begin
              state_d = ST_RESP;
              resp_d  = full ? STAT_FULL : STAT_OK;
              if (!full) begin
                head_d      = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
                mem_we_o    = 1'b1;
                mem_waddr_o = head_d;
                count_d     = count_q + CW'(1);
              end
            end
            KIND_SEARCH: begin
              dump_d = 1'b0;
              if (empty) begin
                state_d = ST_RESP;
                resp_d  = STAT_NOTFOUND;
              end else begin
                state_d  = ST_WALK;
                mem_re_o = 1'b1;
              end
            end
            KIND_REM_HEAD: begin
              state_d = ST_RESP;
              resp_d  = empty ? STAT_EMPTY : STAT_OK;
              if (!empty) begin
                head_d  = ring_pos(head_q, AW'(1));
                count_d = count_q - CW'(1);
              end
            end
            KIND_DUMP: begin
              dump_d = 1'b1;
              if (empty) begin
                state_d = ST_RESP;
                resp_d  = STAT_EMPTY;
              end else begin
                state_d  = ST_WALK;
                mem_re_o = 1'b1;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        mem_raddr_o = ring_pos(head_q, idx_q + AW'(1));
        if (dump_q) begin
          beat = '{result_value: mem_rdata_i, status: STAT_OK, last: last_ent};
          if (slot_free) begin
            out_load = 1'b1;
            if (last_ent) begin
              state_d = ST_IDLE;
            end else begin
              mem_re_o = 1'b1;
              idx_d    = idx_q + AW'(1);
            end
          end
        end else if (mem_rdata_i == val_q) begin
          beat = '{result_value: val_q, status: STAT_OK, last: 1'b1};
          if (slot_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (last_ent) begin
          beat = '{result_value: '0, status: STAT_NOTFOUND, last: 1'b1};
          if (slot_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          mem_re_o = 1'b1;
          idx_d    = idx_q + AW'(1);
        end
      end
      ST_RESP: begin
        beat = '{result_value: '0, status: resp_q, last: 1'b1};
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      dump_q      <= 1'b0;
      resp_q      <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      dump_q  <= dump_d;
      resp_q  <= resp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= in_i.value;
    end
    if (out_load) begin
      out_q <= beat;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_q.result_value;
  assign out_o.status       = out_q.status;
  assign out_o.last         = out_q.last;

endmodule
